### design/lwps_pkg.sv
package lwps_pkg;

   // field widths
   localparam int OP_W    = 2;
   localparam int COORD_W = 10;
   localparam int LEN_W   = 11;
   localparam int COLOR_W = 24;
   localparam int KIND_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int POS_W   = 11;
   localparam int SEQ_W   = 4;

   // request operations
   localparam logic [OP_W-1:0] OP_FULL = 2'd0;
   localparam logic [OP_W-1:0] OP_RECT = 2'd1;
   localparam logic [OP_W-1:0] OP_STEP = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_CMD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PARAM = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DROP  = 2'd3;

   // panel commands
   localparam logic [BYTE_W-1:0] CMD_COL_SET   = 8'h2A;
   localparam logic [BYTE_W-1:0] CMD_PAGE_SET  = 8'h2B;
   localparam logic [BYTE_W-1:0] CMD_MEM_WRITE = 8'h2C;

   localparam logic [COLOR_W-1:0] COLOR_MASK = 24'h7e7e7e;
   localparam logic [POS_W-1:0]   END_MAX    = 11'h7ff;

   // window setup byte order
   localparam logic [SEQ_W-1:0] SEQ_COL_CMD  = 4'd0;
   localparam logic [SEQ_W-1:0] SEQ_XS_HI    = 4'd1;
   localparam logic [SEQ_W-1:0] SEQ_XS_LO    = 4'd2;
   localparam logic [SEQ_W-1:0] SEQ_XE_HI    = 4'd3;
   localparam logic [SEQ_W-1:0] SEQ_XE_LO    = 4'd4;
   localparam logic [SEQ_W-1:0] SEQ_PAGE_CMD = 4'd5;
   localparam logic [SEQ_W-1:0] SEQ_YS_HI    = 4'd6;
   localparam logic [SEQ_W-1:0] SEQ_YS_LO    = 4'd7;
   localparam logic [SEQ_W-1:0] SEQ_YE_HI    = 4'd8;
   localparam logic [SEQ_W-1:0] SEQ_YE_LO    = 4'd9;
   localparam logic [SEQ_W-1:0] SEQ_MEM_CMD  = 4'd10;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [LEN_W-1:0]   w;
      logic [LEN_W-1:0]   h;
   } lwps_rect_type;

   localparam int RECT_W = $bits(lwps_rect_type);

   typedef struct packed {
      logic             capture;
      logic             start_req;
      logic             start_ram;
      logic             enqueue;
      logic             drop;
      logic             pixel;
      logic             dequeue;
      logic             win_load;
      logic [SEQ_W-1:0] win_seq;
   } lwps_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            painting;
      logic            head_pending;
      logic            tail_pending;
      logic            rsp_taken;
   } lwps_status_type;

endpackage

### design/lwps_req_if.sv
interface lwps_req_if import lwps_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [COORD_W-1:0] rect_x;
   logic [COORD_W-1:0] rect_y;
   logic [LEN_W-1:0]   rect_width;
   logic [LEN_W-1:0]   rect_height;
   logic [COLOR_W-1:0] pixel_color;

   modport source (
      output valid, op, rect_x, rect_y, rect_width, rect_height, pixel_color,
      input  ready
   );

   modport sink (
      input  valid, op, rect_x, rect_y, rect_width, rect_height, pixel_color,
      output ready
   );
endinterface

### design/lwps_rsp_if.sv
interface lwps_rsp_if import lwps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] out_byte;
   logic              last;
   logic              busy_res;
   logic [POS_W-1:0]  pixel_x;
   logic [POS_W-1:0]  pixel_y;

   modport source (
      output valid, kind, out_byte, last, busy_res, pixel_x, pixel_y,
      input  ready
   );

   modport sink (
      input  valid, kind, out_byte, last, busy_res, pixel_x, pixel_y,
      output ready
   );
endinterface

### design/lwps_ram.sv
module lwps_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/lwps_ctrl.sv
module lwps_ctrl import lwps_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  lwps_status_type status,
   output lwps_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_RAM      = 3'd2;
   localparam logic [2:0] S_WIN      = 3'd3;
   localparam logic [2:0] S_WIN_WAIT = 3'd4;
   localparam logic [2:0] S_ONE_WAIT = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      seq_in      = seq_ff;
      cmd         = '0;
      cmd.win_seq = seq_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.op inside {OP_FULL, OP_RECT}) begin
               if (!status.painting) begin
                  cmd.start_req = 1'b1;
                  seq_in        = SEQ_COL_CMD;
                  state_in      = S_WIN;
               end else if (status.head_pending) begin
                  cmd.drop = 1'b1;
                  state_in = S_ONE_WAIT;
               end else begin
                  cmd.enqueue = 1'b1;
                  state_in    = S_IDLE;
               end
            end else if (status.op == OP_STEP) begin
               if (status.painting) begin
                  cmd.pixel = 1'b1;
                  state_in  = S_ONE_WAIT;
               end else if (status.tail_pending) begin
                  cmd.dequeue = 1'b1;
                  state_in    = S_RAM;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RAM: begin
            cmd.start_ram = 1'b1;
            seq_in        = SEQ_COL_CMD;
            state_in      = S_WIN;
         end
         S_WIN: begin
            cmd.win_load = 1'b1;
            state_in     = S_WIN_WAIT;
         end
         S_WIN_WAIT: begin
            if (status.rsp_taken) begin
               if (seq_ff == SEQ_MEM_CMD) begin
                  state_in = S_IDLE;
               end else begin
                  seq_in   = seq_ff + 1'b1;
                  state_in = S_WIN;
               end
            end
         end
         S_ONE_WAIT: begin
            if (status.rsp_taken) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         seq_ff   <= '0;
      end else begin
         state_ff <= state_in;
         seq_ff   <= seq_in;
      end
   end

endmodule

### design/lwps_dpath.sv
module lwps_dpath import lwps_pkg::*; #(
   parameter int QUEUE_DEPTH   = 32,
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic               clock,
   input  logic               reset,
   input  lwps_cmd_type       cmd,
   output lwps_status_type    status,
   input  logic [OP_W-1:0]    req_op,
   input  logic [COORD_W-1:0] req_rect_x,
   input  logic [COORD_W-1:0] req_rect_y,
   input  logic [LEN_W-1:0]   req_rect_width,
   input  logic [LEN_W-1:0]   req_rect_height,
   input  logic [COLOR_W-1:0] req_pixel_color,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [KIND_W-1:0]  rsp_kind,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_last,
   output logic               rsp_busy_res,
   output logic [POS_W-1:0]   rsp_pixel_x,
   output logic [POS_W-1:0]   rsp_pixel_y
);

   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam logic [QW-1:0] PTR_LAST = QW'(QUEUE_DEPTH - 1);

   function automatic logic [POS_W-1:0] sat_end(logic [COORD_W-1:0] s, logic [LEN_W-1:0] l);
      logic [POS_W:0] e;
      e = {2'b00, s} + {1'b0, l};
      return (e > {1'b0, END_MAX}) ? END_MAX : e[POS_W-1:0];
   endfunction

   // latched request
   logic [OP_W-1:0]    op_ff;
   lwps_rect_type      rect_ff;
   logic [COLOR_W-1:0] color_ff;

   // raster state
   logic               painting_ff, painting_in;
   logic [POS_W-1:0]   cur_col_ff, cur_col_in;
   logic [POS_W-1:0]   cur_row_ff, cur_row_in;
   logic [COORD_W-1:0] row_start_ff, row_start_in;
   logic [POS_W-1:0]   end_col_ff, end_col_in;
   logic [POS_W-1:0]   end_row_ff, end_row_in;
   logic [1:0]         byte_idx_ff, byte_idx_in;
   logic [COLOR_W-1:0] held_ff, held_in;

   // queue state
   logic [QUEUE_DEPTH-1:0] pending_ff, pending_in;
   logic [QW-1:0]          head_ff, head_in;
   logic [QW-1:0]          tail_ff, tail_in;
   logic [RECT_W-1:0]      ram_rd_data;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [KIND_W-1:0] out_kind_ff, out_kind_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;

   lwps_rect_type      req_rect;
   lwps_rect_type      src_rect;
   logic [COLOR_W-1:0] masked;
   logic [POS_W-1:0]   col_inc;
   logic [POS_W-1:0]   row_inc;
   logic [15:0]        x_end;
   logic [15:0]        y_end;
   logic [BYTE_W-1:0]  win_byte;
   logic [KIND_W-1:0]  win_kind;

   lwps_ram #(
      .WIDTH (RECT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.enqueue),
      .wr_addr (head_ff),
      .wr_data (req_rect),
      .rd_en   (cmd.dequeue),
      .rd_addr (tail_ff),
      .rd_data (ram_rd_data)
   );

   // latch the accepted request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         rect_ff  <= '{x: req_rect_x, y: req_rect_y, w: req_rect_width, h: req_rect_height};
         color_ff <= req_pixel_color;
      end
   end

   // full paint stands for the whole screen
   always_comb begin
      if (op_ff == OP_FULL) begin
         req_rect = '{x: '0, y: '0, w: LEN_W'(SCREEN_WIDTH), h: LEN_W'(SCREEN_HEIGHT)};
      end else begin
         req_rect = rect_ff;
      end
      src_rect = cmd.start_ram ? lwps_rect_type'(ram_rd_data) : req_rect;
   end

   assign masked  = color_ff & COLOR_MASK;
   assign col_inc = cur_col_ff + 1'b1;
   assign row_inc = cur_row_ff + 1'b1;

   // raster and queue updates
   always_comb begin
      painting_in  = painting_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      row_start_in = row_start_ff;
      end_col_in   = end_col_ff;
      end_row_in   = end_row_ff;
      byte_idx_in  = byte_idx_ff;
      held_in      = held_ff;
      pending_in   = pending_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;

      if (cmd.start_req || cmd.start_ram) begin
         painting_in  = 1'b1;
         cur_col_in   = {1'b0, src_rect.x};
         cur_row_in   = {1'b0, src_rect.y};
         row_start_in = src_rect.x;
         end_col_in   = sat_end(src_rect.x, src_rect.w);
         end_row_in   = sat_end(src_rect.y, src_rect.h);
         byte_idx_in  = 2'd0;
      end

      if (cmd.enqueue) begin
         pending_in[head_ff] = 1'b1;
         head_in = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
      end

      if (cmd.dequeue) begin
         pending_in[tail_ff] = 1'b0;
         tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
      end

      if (cmd.pixel) begin
         case (byte_idx_ff)
            2'd0: begin
               held_in     = masked;
               byte_idx_in = 2'd1;
            end
            2'd1: begin
               byte_idx_in = 2'd2;
            end
            default: begin
               byte_idx_in = 2'd0;
               if (col_inc >= end_col_ff) begin
                  cur_col_in = {1'b0, row_start_ff};
                  cur_row_in = row_inc;
                  if (row_inc >= end_row_ff) begin
                     painting_in = 1'b0;
                  end
               end else begin
                  cur_col_in = col_inc;
               end
            end
         endcase
      end
   end

   // window setup bytes come from the live window registers
   assign x_end = {5'b0, end_col_ff} - 16'd1;
   assign y_end = {5'b0, end_row_ff} - 16'd1;

   always_comb begin
      win_kind = KIND_PARAM;
      case (cmd.win_seq)
         SEQ_COL_CMD: begin
            win_kind = KIND_CMD;
            win_byte = CMD_COL_SET;
         end
         SEQ_XS_HI:  win_byte = BYTE_W'(row_start_ff >> 8);
         SEQ_XS_LO:  win_byte = row_start_ff[7:0];
         SEQ_XE_HI:  win_byte = x_end[15:8];
         SEQ_XE_LO:  win_byte = x_end[7:0];
         SEQ_PAGE_CMD: begin
            win_kind = KIND_CMD;
            win_byte = CMD_PAGE_SET;
         end
         SEQ_YS_HI:  win_byte = BYTE_W'(cur_row_ff >> 8);
         SEQ_YS_LO:  win_byte = cur_row_ff[7:0];
         SEQ_YE_HI:  win_byte = y_end[15:8];
         SEQ_YE_LO:  win_byte = y_end[7:0];
         default: begin
            win_kind = KIND_CMD;
            win_byte = CMD_MEM_WRITE;
         end
      endcase
   end

   // result register loads
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_kind_in  = out_kind_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (cmd.win_load) begin
         out_valid_in = 1'b1;
         out_kind_in  = win_kind;
         out_byte_in  = win_byte;
         out_last_in  = (cmd.win_seq == SEQ_MEM_CMD);
      end else if (cmd.drop) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_DROP;
         out_byte_in  = '0;
         out_last_in  = 1'b1;
      end else if (cmd.pixel) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_PIXEL;
         out_last_in  = 1'b1;
         case (byte_idx_ff)
            2'd0:    out_byte_in = masked[23:16];
            2'd1:    out_byte_in = held_ff[15:8];
            default: out_byte_in = held_ff[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         painting_ff  <= 1'b0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         row_start_ff <= '0;
         end_col_ff   <= POS_W'(SCREEN_WIDTH);
         end_row_ff   <= POS_W'(SCREEN_HEIGHT);
         byte_idx_ff  <= '0;
         held_ff      <= '0;
         pending_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         painting_ff  <= painting_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         row_start_ff <= row_start_in;
         end_col_ff   <= end_col_in;
         end_row_ff   <= end_row_in;
         byte_idx_ff  <= byte_idx_in;
         held_ff      <= held_in;
         pending_ff   <= pending_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff <= out_kind_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   // status back to the controller
   assign status.op           = op_ff;
   assign status.painting     = painting_ff;
   assign status.head_pending = pending_ff[head_ff];
   assign status.tail_pending = pending_ff[tail_ff];
   assign status.rsp_taken    = out_valid_ff && rsp_ready;

   assign rsp_valid    = out_valid_ff;
   assign rsp_kind     = out_kind_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_busy_res = painting_ff;
   assign rsp_pixel_x  = cur_col_ff;
   assign rsp_pixel_y  = cur_row_ff;

endmodule

### design/lcd_window_paint_queue_streamer_core.sv
// a pixel step or dropped request is decoded after acceptance, then its byte is registered
// a started window gives 11 bytes, each held until taken; a queued window first reads the ram
// one request at a time: a new request is accepted only while the controller is idle
// steps follow the controller sequence and the registered read of the pending-rectangle ram
// reset: synchronous, clears raster state, ring pointers and pending bits; no clearing pass
module lcd_window_paint_queue_streamer_core import lwps_pkg::*; #(
   parameter int QUEUE_DEPTH   = 32,
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic          clock,
   input  logic          reset,
   lwps_req_if.sink      req_if,
   lwps_rsp_if.source    rsp_if
);

   lwps_cmd_type    cmd;
   lwps_status_type status;

   // sequencing of each request
   lwps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // raster, ring and result register
   lwps_dpath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_if.op),
      .req_rect_x      (req_if.rect_x),
      .req_rect_y      (req_if.rect_y),
      .req_rect_width  (req_if.rect_width),
      .req_rect_height (req_if.rect_height),
      .req_pixel_color (req_if.pixel_color),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_kind        (rsp_if.kind),
      .rsp_out_byte    (rsp_if.out_byte),
      .rsp_last        (rsp_if.last),
      .rsp_busy_res    (rsp_if.busy_res),
      .rsp_pixel_x     (rsp_if.pixel_x),
      .rsp_pixel_y     (rsp_if.pixel_y)
   );

endmodule
